/* design/afk_pkg.sv */
// Shared types, constants and helpers for the arm forward kinematics block.
// Used by every module in the design folder; depends on nothing else.
package afk_pkg;

    // Field widths fixed by the interface
    localparam int LEN_W      = 18;
    localparam int IN_ANG_W   = 16;
    localparam int POS_W      = 20;
    localparam int POS_PRE_W  = 24;

    // Link length reset values, 1/256 mm
    localparam logic [LEN_W-1:0] RST_UPPER_ARM  = 18'd48640;
    localparam logic [LEN_W-1:0] RST_FOREARM    = 18'd35584;
    localparam logic [LEN_W-1:0] RST_WRIST_LINK = 18'd37709;
    localparam logic [LEN_W-1:0] RST_TOOL_LINK  = 18'd42496;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_UPPER_ARM  = 2'd0,
        CFG_FOREARM    = 2'd1,
        CFG_WRIST_LINK = 2'd2,
        CFG_TOOL_LINK  = 2'd3
    } t_cfg_idx;

    // Joint slots in the trig arrays
    localparam int J_SH   = 0;
    localparam int J_EL   = 1;
    localparam int J_WR   = 2;
    localparam int J_BASE = 3;
    localparam int N_JNT  = 4;

    // Sine polynomial in Q30, Horner in u^2 from the highest term down
    localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
    localparam logic [30:0] HORNER_K13 = 31'd61;
    localparam int          N_HORNER   = 6;
    localparam logic [30:0] HORNER_K [N_HORNER] = '{
        31'd3864, 31'd172272, 31'd5026995, 31'd85569306, 31'd693598668, 31'd1686629713
    };

    // Pipeline depths
    localparam int SINE_LAT = N_HORNER + 4;
    localparam int COMB_LAT = 5;
    localparam int PIPE_LAT = 1 + SINE_LAT + COMB_LAT;

    // Saturation bounds of the position outputs
    localparam logic signed [POS_PRE_W-1:0] POS_HI = 24'sd524287;
    localparam logic signed [POS_PRE_W-1:0] POS_LO = -24'sd524288;

    typedef struct packed {
        logic [IN_ANG_W-1:0] base_angle;
        logic [IN_ANG_W-1:0] shoulder_angle;
        logic [IN_ANG_W-1:0] elbow_angle;
        logic [IN_ANG_W-1:0] wrist_angle;
    } t_in_word;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_out_word;

    // State handed from one Horner cell to the next
    typedef struct packed {
        logic [30:0] p;
        logic [30:0] u;
        logic [30:0] u2;
        logic [1:0]  quad;
    } t_horner;

    // Clamp a rounded position to the output range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [POS_PRE_W-1:0] v);
        logic signed [POS_PRE_W-1:0] c;
        if (v > POS_HI) begin
            c = POS_HI;
        end else if (v < POS_LO) begin
            c = POS_LO;
        end else begin
            c = v;
        end
        return c[POS_W-1:0];
    endfunction

endpackage

/* design/arm_forward_kinematics.sv */
// Forward kinematics of a four-joint arm: encoder angles in, tool x/y/z out.
// Top level; uses afk_pkg, afk_sine and afk_combine.
//
// Takes one word of four joint angles per clock while o_stall is low and
// returns one position word per input word, in order. The path is a fixed
// pipeline: an angle correction register, a 10-stage sine unit (a row of six
// Horner cells between a fold stage, a squaring stage and two output stages)
// run eight times in parallel for the sines and cosines of all joints, and a
// 5-stage length-weighting and base-rotation stage into the output register.
// A finished word waiting on o_valid does not stop intake; the pipe holds
// only when its last stage is full, the output register is full and i_stall
// is high. Link lengths must be written through the config port only while no
// word is in flight (not enforced by the block) and apply to the next word.
module arm_forward_kinematics
    import afk_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int TRIG_BITS  = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  t_in_word         i_data,
    output logic             o_valid,
    input  logic             i_stall,
    output t_out_word        o_data,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [LEN_W-1:0] i_cfg_data
);

    localparam int SIN_W = TRIG_BITS + 2;
    localparam logic [ANGLE_BITS-1:0] QTR  = {2'b01, {(ANGLE_BITS-2){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] HALF = {1'b1, {(ANGLE_BITS-1){1'b0}}};

    logic [LEN_W-1:0]      r_l1, r_l2, r_l3, r_l4;
    logic [LEN_W:0]        w_l34;
    logic                  w_en;
    logic [PIPE_LAT-1:0]   r_vld;
    logic [ANGLE_BITS-1:0] w_in_sh, w_in_el, w_in_wr, w_in_base;
    logic [ANGLE_BITS-1:0] n_ang [N_JNT];
    logic [ANGLE_BITS-1:0] r_ang [N_JNT];
    logic signed [SIN_W-1:0] w_sin [N_JNT];
    logic signed [SIN_W-1:0] w_cos [N_JNT];
    t_out_word             w_pos;
    t_out_word             r_out;
    logic                  r_out_valid;

    // Link length registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1 <= RST_UPPER_ARM;
            r_l2 <= RST_FOREARM;
            r_l3 <= RST_WRIST_LINK;
            r_l4 <= RST_TOOL_LINK;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_UPPER_ARM:  r_l1 <= i_cfg_data;
                CFG_FOREARM:    r_l2 <= i_cfg_data;
                CFG_WRIST_LINK: r_l3 <= i_cfg_data;
                CFG_TOOL_LINK:  r_l4 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_l34 = {1'b0, r_l3} + {1'b0, r_l4};

    // Advance the pipe unless the last stage cannot hand off its word
    assign w_en    = !(r_vld[PIPE_LAT-1] && r_out_valid && i_stall);
    assign o_stall = !w_en;

    // Correct the encoders and accumulate the joint angles
    assign w_in_base = ANGLE_BITS'(i_data.base_angle);
    assign w_in_sh   = ANGLE_BITS'(i_data.shoulder_angle);
    assign w_in_el   = ANGLE_BITS'(i_data.elbow_angle);
    assign w_in_wr   = ANGLE_BITS'(i_data.wrist_angle);

    always_comb begin
        n_ang[J_BASE] = w_in_base;
        n_ang[J_SH]   = w_in_sh - QTR;
        n_ang[J_EL]   = w_in_el - HALF + n_ang[J_SH];
        n_ang[J_WR]   = HALF - w_in_wr + n_ang[J_EL];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ang <= n_ang;
        end
    end

    // Track which stages hold a word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    // Sine and cosine of every joint
    for (genvar g = 0; g < N_JNT; g++) begin : g_trig
        afk_sine #(
            .ANGLE_BITS (ANGLE_BITS),
            .TRIG_BITS  (TRIG_BITS)
        ) u_sin (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (r_ang[g]),
            .o_sine  (w_sin[g])
        );

        afk_sine #(
            .ANGLE_BITS (ANGLE_BITS),
            .TRIG_BITS  (TRIG_BITS)
        ) u_cos (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_angle (r_ang[g] + QTR),
            .o_sine  (w_cos[g])
        );
    end

    afk_combine #(
        .TRIG_BITS (TRIG_BITS)
    ) u_combine (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_sin     (w_sin),
        .i_cos     (w_cos),
        .i_len_l1  (r_l1),
        .i_len_l2  (r_l2),
        .i_len_l34 (w_l34),
        .o_pos     (w_pos)
    );

    // Output register: load from the last stage, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en && r_vld[PIPE_LAT-1]) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[PIPE_LAT-1]) begin
            r_out <= w_pos;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

/* design/afk_horner_cell.sv */
// One Horner step of the sine polynomial: p <= k - (p * u2) >> 30.
// Depends on afk_pkg for the t_horner hand-off struct.
module afk_horner_cell
    import afk_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_coef,
    input  t_horner     i_h,
    output t_horner     o_h
);

    logic [61:0] w_prod;
    t_horner     n_h;
    t_horner     r_h;

    // Multiply by u^2, drop 30 fraction bits, subtract from the coefficient
    assign w_prod = 62'(i_h.p) * 62'(i_h.u2);

    always_comb begin
        n_h      = i_h;
        n_h.p    = i_coef - w_prod[60:30];
    end

    // Advance the chain
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h <= n_h;
        end
    end

    assign o_h = r_h;

endmodule

/* design/afk_sine.sv */
// Pipelined fixed-point sine of a binary angle: quadrant fold, u^2, a chain
// of Horner cells, final multiply, clamp and rounding. Uses afk_pkg, afk_horner_cell.
module afk_sine
    import afk_pkg::*;
#(
    parameter int ANGLE_BITS = 16,
    parameter int TRIG_BITS  = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [ANGLE_BITS-1:0]       i_angle,
    output logic signed [TRIG_BITS+1:0] o_sine
);

    localparam int USH = 32 - ANGLE_BITS;
    localparam int RSH = 30 - TRIG_BITS;
    localparam logic [31:0] RND_HALF = 32'(64'd1 << (RSH - 1));

    logic [1:0]  w_quad;
    logic [30:0] w_u_raw;
    logic [30:0] n_u0;
    logic [30:0] r_u0;
    logic [1:0]  r_quad0;
    logic [61:0] w_uu;
    t_horner     r_h0;
    t_horner     w_h [N_HORNER+1];
    logic [61:0] w_pu;
    logic [31:0] r_v;
    logic [1:0]  r_vquad;
    logic [30:0] w_vc;
    logic [31:0] w_rnd;
    logic [TRIG_BITS:0] w_mag;
    logic signed [TRIG_BITS+1:0] w_pos;
    logic signed [TRIG_BITS+1:0] r_sine;

    // Fold the angle into the first quadrant, u in Q30
    assign w_quad  = i_angle[ANGLE_BITS-1:ANGLE_BITS-2];
    assign w_u_raw = {1'b0, i_angle[ANGLE_BITS-3:0], {USH{1'b0}}};
    assign n_u0    = w_quad[0] ? (ONE_Q30 - w_u_raw) : w_u_raw;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_u0    <= n_u0;
            r_quad0 <= w_quad;
        end
    end

    // Square u and seed the Horner chain with the top coefficient
    assign w_uu = 62'(r_u0) * 62'(r_u0);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_h0.p    <= HORNER_K13;
            r_h0.u    <= r_u0;
            r_h0.u2   <= w_uu[60:30];
            r_h0.quad <= r_quad0;
        end
    end

    assign w_h[0] = r_h0;

    // Chain of Horner cells
    for (genvar g = 0; g < N_HORNER; g++) begin : g_cell
        afk_horner_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_coef (HORNER_K[g]),
            .i_h    (w_h[g]),
            .o_h    (w_h[g+1])
        );
    end

    // Final multiply by u
    assign w_pu = 62'(w_h[N_HORNER].p) * 62'(w_h[N_HORNER].u);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_v     <= w_pu[61:30];
            r_vquad <= w_h[N_HORNER].quad;
        end
    end

    // Clamp to one, round half up, apply the sign of the lower half turn
    assign w_vc  = (r_v > 32'(ONE_Q30)) ? ONE_Q30 : r_v[30:0];
    assign w_rnd = 32'(w_vc) + RND_HALF;
    assign w_mag = w_rnd[30:RSH];
    assign w_pos = $signed({1'b0, w_mag});

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sine <= r_vquad[1] ? -w_pos : w_pos;
        end
    end

    assign o_sine = r_sine;

endmodule

/* design/afk_combine.sv */
// Link sums and base rotation: weights the joint sines and cosines by the
// link lengths, rounds, rotates the reach by the base angle and saturates. Uses afk_pkg.
module afk_combine
    import afk_pkg::*;
#(
    parameter int TRIG_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [TRIG_BITS+1:0] i_sin [N_JNT],
    input  logic signed [TRIG_BITS+1:0] i_cos [N_JNT],
    input  logic [LEN_W-1:0]            i_len_l1,
    input  logic [LEN_W-1:0]            i_len_l2,
    input  logic [LEN_W:0]              i_len_l34,
    output t_out_word                   o_pos
);

    localparam int SIN_W  = TRIG_BITS + 2;
    localparam int PROD_W = TRIG_BITS + 22;
    localparam int SUM_W  = TRIG_BITS + 24;
    localparam int RQ_W   = 30;
    localparam int RQ_SH  = TRIG_BITS - 8;
    localparam int XY_SH  = TRIG_BITS + 8;
    localparam int XP_W   = SIN_W + RQ_W;
    localparam logic signed [SUM_W-1:0] RQ_HALF = SUM_W'(64'd1 << (RQ_SH - 1));
    localparam logic signed [SUM_W-1:0] Z_HALF  = SUM_W'(64'd1 << (TRIG_BITS - 1));
    localparam logic signed [XP_W-1:0]  XY_HALF = XP_W'(64'd1 << (XY_SH - 1));

    logic signed [LEN_W+1:0]   w_len [3];
    logic signed [PROD_W-1:0]  r_sprod [3];
    logic signed [PROD_W-1:0]  r_cprod [3];
    logic signed [SIN_W-1:0]   r0_bs, r0_bc, r1_bs, r1_bc, r2_bs, r2_bc;
    logic signed [SUM_W-1:0]   r_reach, r_zsum;
    logic signed [SUM_W-1:0]   w_reach_rnd, w_reach_sh, w_z_rnd, w_z_sh;
    logic signed [RQ_W-1:0]    r_rq;
    logic signed [POS_PRE_W-1:0] r2_z, r3_z;
    logic signed [XP_W-1:0]    r_xp, r_yp;
    logic signed [XP_W-1:0]    w_x_rnd, w_y_rnd, w_x_sh, w_y_sh;
    t_out_word                 r_pos;

    assign w_len[0] = $signed({2'b00, i_len_l1});
    assign w_len[1] = $signed({2'b00, i_len_l2});
    assign w_len[2] = $signed({1'b0, i_len_l34});

    // Weight each joint term by its link length; hold the base trig
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_sprod[j] <= PROD_W'(w_len[j]) * PROD_W'(i_sin[j]);
                r_cprod[j] <= PROD_W'(w_len[j]) * PROD_W'(i_cos[j]);
            end
            r0_bs <= i_sin[J_BASE];
            r0_bc <= i_cos[J_BASE];
        end
    end

    // Sum the radial reach and the height
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_reach <= SUM_W'(r_sprod[0]) + SUM_W'(r_sprod[1]) + SUM_W'(r_sprod[2]);
            r_zsum  <= SUM_W'(r_cprod[0]) + SUM_W'(r_cprod[1]) + SUM_W'(r_cprod[2]);
            r1_bs   <= r0_bs;
            r1_bc   <= r0_bc;
        end
    end

    // Round the reach to 1/65536 mm and the height to 1/256 mm
    assign w_reach_rnd = r_reach + RQ_HALF;
    assign w_reach_sh  = w_reach_rnd >>> RQ_SH;
    assign w_z_rnd     = r_zsum + Z_HALF;
    assign w_z_sh      = w_z_rnd >>> TRIG_BITS;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rq  <= w_reach_sh[RQ_W-1:0];
            r2_z  <= w_z_sh[POS_PRE_W-1:0];
            r2_bs <= r1_bs;
            r2_bc <= r1_bc;
        end
    end

    // Rotate the reach by the base angle
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xp <= XP_W'(r2_bc) * XP_W'(r_rq);
            r_yp <= XP_W'(r2_bs) * XP_W'(r_rq);
            r3_z <= r2_z;
        end
    end

    // Round to 1/256 mm and saturate
    assign w_x_rnd = r_xp + XY_HALF;
    assign w_y_rnd = r_yp + XY_HALF;
    assign w_x_sh  = w_x_rnd >>> XY_SH;
    assign w_y_sh  = w_y_rnd >>> XY_SH;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pos.pos_x <= sat_pos(w_x_sh[POS_PRE_W-1:0]);
            r_pos.pos_y <= sat_pos(w_y_sh[POS_PRE_W-1:0]);
            r_pos.pos_z <= sat_pos(r3_z);
        end
    end

    assign o_pos = r_pos;

endmodule
